@@ hdl/lpt_pkg.sv @@
// ----------------------------------------------------------------------------
// lpt_pkg: line protocol tokenizer shared definitions
// Token kinds, value types, line status codes and the result record.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int POS_W    = 12;
  localparam int MAX_LINE = 4096;
  localparam int FIELD_MAX = (1 << POS_W) - 1;

  localparam logic [2:0] KIND_MEAS    = 3'd0;
  localparam logic [2:0] KIND_TAG_KEY = 3'd1;
  localparam logic [2:0] KIND_TAG_VAL = 3'd2;
  localparam logic [2:0] KIND_FLD_KEY = 3'd3;
  localparam logic [2:0] KIND_FLD_VAL = 3'd4;
  localparam logic [2:0] KIND_TSTAMP  = 3'd5;

  localparam logic [2:0] VT_NONE    = 3'd0;
  localparam logic [2:0] VT_INTEGER = 3'd1;
  localparam logic [2:0] VT_DOUBLE  = 3'd2;
  localparam logic [2:0] VT_STRING  = 3'd3;
  localparam logic [2:0] VT_WSTRING = 3'd4;
  localparam logic [2:0] VT_BOOLEAN = 3'd5;

  localparam logic [1:0] ST_TOKEN   = 2'd0;
  localparam logic [1:0] ST_LINE_OK = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  typedef struct packed {
    logic [2:0]       token_kind;
    logic [2:0]       value_type;
    logic [POS_W-1:0] token_start;
    logic [POS_W-1:0] token_length;
    logic [POS_W-1:0] content_length;
    logic [63:0]      int_value;
    logic [1:0]       line_status;
  } lpt_result_t;

  typedef struct packed {
    logic        emit;
    lpt_result_t result;
  } lpt_step_t;

endpackage

@@ hdl/lpt_in_stage.sv @@
// ----------------------------------------------------------------------------
// lpt_in_stage: input register
// Captures one byte transaction and holds it until the tokenizer step takes it.
// ----------------------------------------------------------------------------
module lpt_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       take,
  output logic       valid,
  output logic [7:0] data_byte,
  output logic       line_end
);

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data_byte <= s_tdata;
      line_end  <= s_tlast;
    end
  end

endmodule

@@ hdl/lpt_step.sv @@
// ----------------------------------------------------------------------------
// lpt_step: tokenizer state and per-byte step
// Holds section, offsets, leading characters and the number accumulator, and
// classifies and closes tokens one byte at a time.
// ----------------------------------------------------------------------------
module lpt_step #(
  parameter int MAX_LINE = lpt_pkg::MAX_LINE
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          data_byte,
  input  logic                line_end,
  output lpt_pkg::lpt_step_t  step
);

  localparam int POS_W     = lpt_pkg::POS_W;
  localparam int CAP_I     = (MAX_LINE - 1 < lpt_pkg::FIELD_MAX) ? MAX_LINE - 1
                                                                  : lpt_pkg::FIELD_MAX;
  localparam logic [POS_W-1:0] POS_CAP = CAP_I[POS_W-1:0];
  localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [2:0]       section,  section_next;
  logic [POS_W-1:0] position, position_next;
  logic [POS_W-1:0] start_offset, start_offset_next;
  logic [7:0]       first_char, first_char_next;
  logic [7:0]       second_char, second_char_next;
  logic [7:0]       prev_char, prev_char_next;
  logic [63:0]      accumulator, accumulator_next;
  logic             fl_neg, fl_neg_next;
  logic             fl_digit, fl_digit_next;
  logic             fl_stop, fl_stop_next;

  logic [POS_W-1:0] len;
  logic [POS_W:0]   len_p1;
  logic [POS_W-1:0] len_p1_sat;
  logic [POS_W-1:0] pos_inc;
  logic             delim;
  logic             is_dig;
  logic [67:0]      prod;
  logic [63:0]      acc_fed;
  logic             neg_fed, digit_fed, stop_fed;
  logic             feed;
  logic [63:0]      num_acc;
  logic             num_neg;
  logic [63:0]      num_value;
  logic [2:0]       vt;
  logic [POS_W-1:0] vcontent;
  logic [63:0]      vvalue;
  lpt_pkg::lpt_result_t res;
  logic             emit;

  always_comb begin
    len        = (position >= start_offset) ? position - start_offset : '0;
    len_p1     = {1'b0, len} + {{POS_W{1'b0}}, 1'b1};
    len_p1_sat = len_p1[POS_W] ? {POS_W{1'b1}} : len_p1[POS_W-1:0];
    pos_inc    = (position < POS_CAP) ? position + {{(POS_W-1){1'b0}}, 1'b1} : position;

    case (section)
      lpt_pkg::KIND_TAG_KEY, lpt_pkg::KIND_FLD_KEY: delim = (data_byte == "=");
      lpt_pkg::KIND_TSTAMP:                         delim = 1'b0;
      default: delim = (data_byte == ",") || (data_byte == " ");
    endcase

    is_dig = data_byte inside {["0":"9"]};
    prod   = ({4'b0, accumulator} << 3) + ({4'b0, accumulator} << 1)
           + {64'b0, data_byte[3:0]};

    acc_fed   = accumulator;
    neg_fed   = fl_neg;
    digit_fed = fl_digit;
    stop_fed  = fl_stop;
    feed = (section == lpt_pkg::KIND_TAG_VAL) || (section == lpt_pkg::KIND_FLD_VAL) ||
           (section == lpt_pkg::KIND_TSTAMP);
    if (feed && !fl_stop) begin
      if (is_dig) begin
        acc_fed   = (prod > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : prod[63:0];
        digit_fed = 1'b1;
      end else if (len == '0 && (data_byte == "-" || data_byte == "+")) begin
        if (data_byte == "-") begin
          neg_fed = 1'b1;
        end
      end else begin
        stop_fed = 1'b1;
      end
    end

    num_acc = delim ? accumulator : acc_fed;
    num_neg = delim ? fl_neg : neg_fed;
    if (num_neg) begin
      num_value = num_acc[63] ? MAG_LIMIT : 64'd0 - num_acc;
    end else begin
      num_value = num_acc[63] ? POS_LIMIT : num_acc;
    end

    vt       = lpt_pkg::VT_NONE;
    vcontent = len;
    vvalue   = '0;
    if (len == '0) begin
      vt = lpt_pkg::VT_NONE;
    end else if ((first_char inside {["0":"9"]}) || first_char == "-") begin
      if (prev_char == "i") begin
        vt     = lpt_pkg::VT_INTEGER;
        vvalue = num_value;
      end else begin
        vt = lpt_pkg::VT_DOUBLE;
      end
    end else if (first_char == "L" && len >= POS_W'(2) && second_char == "\"") begin
      vt       = lpt_pkg::VT_WSTRING;
      vcontent = (len >= POS_W'(3)) ? len - POS_W'(3) : '0;
    end else if (first_char == "\"") begin
      vt       = lpt_pkg::VT_STRING;
      vcontent = (len >= POS_W'(2)) ? len - POS_W'(2) : '0;
    end else if (first_char == "t" || first_char == "T" ||
                 first_char == "f" || first_char == "F") begin
      vt     = lpt_pkg::VT_BOOLEAN;
      vvalue = (first_char == "t" || first_char == "T") ? 64'd1 : 64'd0;
    end

    section_next      = section;
    position_next     = position;
    start_offset_next = start_offset;
    first_char_next   = first_char;
    second_char_next  = second_char;
    prev_char_next    = prev_char;
    accumulator_next  = accumulator;
    fl_neg_next       = fl_neg;
    fl_digit_next     = fl_digit;
    fl_stop_next      = fl_stop;
    emit              = 1'b0;

    res.token_kind     = section;
    res.value_type     = lpt_pkg::VT_NONE;
    res.token_start    = start_offset;
    res.token_length   = len_p1_sat;
    res.content_length = len_p1_sat;
    res.int_value      = '0;
    res.line_status    = lpt_pkg::ST_ERROR;

    if (!delim) begin
      if (line_end) begin
        emit = 1'b1;
        if (section == lpt_pkg::KIND_TSTAMP) begin
          res.value_type  = digit_fed ? lpt_pkg::VT_INTEGER : lpt_pkg::VT_NONE;
          res.int_value   = digit_fed ? num_value : '0;
          res.line_status = lpt_pkg::ST_LINE_OK;
        end
      end else begin
        if (len == '0) begin
          first_char_next = data_byte;
        end else if (len == POS_W'(1)) begin
          second_char_next = data_byte;
        end
        accumulator_next = acc_fed;
        fl_neg_next      = neg_fed;
        fl_digit_next    = digit_fed;
        fl_stop_next     = stop_fed;
        prev_char_next   = data_byte;
        position_next    = pos_inc;
      end
    end else begin
      emit = 1'b1;
      if (line_end) begin
        if (section == lpt_pkg::KIND_FLD_VAL && data_byte == " ") begin
          res.value_type     = vt;
          res.token_length   = len;
          res.content_length = vcontent;
          res.int_value      = vvalue;
          res.line_status    = lpt_pkg::ST_LINE_OK;
        end
      end else begin
        res.token_length   = len;
        res.content_length = len;
        res.line_status    = lpt_pkg::ST_TOKEN;
        if (section == lpt_pkg::KIND_TAG_VAL || section == lpt_pkg::KIND_FLD_VAL) begin
          res.value_type     = vt;
          res.content_length = vcontent;
          res.int_value      = vvalue;
        end
        case (section)
          lpt_pkg::KIND_MEAS, lpt_pkg::KIND_TAG_VAL:
            section_next = (data_byte == ",") ? lpt_pkg::KIND_TAG_KEY : lpt_pkg::KIND_FLD_KEY;
          lpt_pkg::KIND_TAG_KEY: section_next = lpt_pkg::KIND_TAG_VAL;
          lpt_pkg::KIND_FLD_KEY: section_next = lpt_pkg::KIND_FLD_VAL;
          default:
            section_next = (data_byte == ",") ? lpt_pkg::KIND_FLD_KEY : lpt_pkg::KIND_TSTAMP;
        endcase
        first_char_next   = '0;
        second_char_next  = '0;
        accumulator_next  = '0;
        fl_neg_next       = 1'b0;
        fl_digit_next     = 1'b0;
        fl_stop_next      = 1'b0;
        prev_char_next    = data_byte;
        start_offset_next = pos_inc;
        position_next     = pos_inc;
      end
    end

    step.emit   = emit;
    step.result = res;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && line_end)) begin
      section      <= lpt_pkg::KIND_MEAS;
      position     <= '0;
      start_offset <= '0;
      first_char   <= '0;
      second_char  <= '0;
      prev_char    <= '0;
      accumulator  <= '0;
      fl_neg       <= 1'b0;
      fl_digit     <= 1'b0;
      fl_stop      <= 1'b0;
    end else if (advance) begin
      section      <= section_next;
      position     <= position_next;
      start_offset <= start_offset_next;
      first_char   <= first_char_next;
      second_char  <= second_char_next;
      prev_char    <= prev_char_next;
      accumulator  <= accumulator_next;
      fl_neg       <= fl_neg_next;
      fl_digit     <= fl_digit_next;
      fl_stop      <= fl_stop_next;
    end
  end

endmodule

@@ hdl/lpt_out_stage.sv @@
// ----------------------------------------------------------------------------
// lpt_out_stage: result register
// Holds one token transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module lpt_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  lpt_pkg::lpt_result_t load_result,
  output logic                 free,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output lpt_pkg::lpt_result_t result
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_result;
    end
  end

endmodule

@@ hdl/line_protocol_tokenizer_core.sv @@
// Path: input register, step logic, result register, then the master side.
// One byte per cycle unless stalled; step logic closes at most one token per byte.
// Stalls on the master side back up through the result register and input register.
// Reset (rst, synchronous) empties both registers and returns the tokenizer to the
// measurement section at offset zero; a line's final byte also resets the tokenizer.
// ----------------------------------------------------------------------------
// line_protocol_tokenizer_core: line protocol tokenizer
// Splits a byte stream of text lines into measurement, tag, field and timestamp
// tokens with offsets, lengths, value class and parsed integer value.
// ----------------------------------------------------------------------------
module line_protocol_tokenizer_core #(
  parameter int MAX_LINE = lpt_pkg::MAX_LINE
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte[7:0]
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // token_start[11:0], token_length[23:12],
                                  // content_length[35:24], int_value[99:36],
                                  // line_status[101:100], zero[103:102]
  output logic [5:0]   m_tuser    // token_kind[2:0], value_type[5:3]
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 in_end;
  logic                 out_free;
  logic                 advance;
  lpt_pkg::lpt_step_t   step;
  lpt_pkg::lpt_result_t res;

  assign advance = in_valid && out_free;

  lpt_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .take      (advance),
    .valid     (in_valid),
    .data_byte (in_byte),
    .line_end  (in_end)
  );

  lpt_step #(
    .MAX_LINE (MAX_LINE)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (in_byte),
    .line_end  (in_end),
    .step      (step)
  );

  lpt_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && step.emit),
    .load_result (step.result),
    .free        (out_free),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .result      (res)
  );

  assign m_tuser = {res.value_type, res.token_kind};
  assign m_tdata = {2'b00, res.line_status, res.int_value, res.content_length,
                    res.token_length, res.token_start};

endmodule

@@ hdl/lpt_checker.sv @@
// ----------------------------------------------------------------------------
// lpt_checker: port checks for the line protocol tokenizer
// Watches the master side for result codes and stall behavior.
// ----------------------------------------------------------------------------
module lpt_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic [5:0]   m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_codes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[2:0] <= lpt_pkg::KIND_TSTAMP &&
                 m_tuser[5:3] <= lpt_pkg::VT_BOOLEAN &&
                 m_tdata[101:100] <= lpt_pkg::ST_ERROR)
    else $error("result code out of range");

  a_tstamp_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[101:100] == lpt_pkg::ST_TOKEN |->
      m_tuser[2:0] != lpt_pkg::KIND_TSTAMP)
    else $error("timestamp token before line end");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[101:100] == lpt_pkg::ST_ERROR |->
      m_tuser[5:3] == lpt_pkg::VT_NONE && m_tdata[99:36] == 64'd0)
    else $error("error result carries a value");

endmodule

bind line_protocol_tokenizer_core lpt_checker u_lpt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
